### src/hcbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix-code bit packer package
// Shared widths, table size and operation codes of the bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    localparam int TABLE_DEPTH      = 256;
    localparam int SYM_W            = 8;
    localparam int CODE_W           = 32;
    localparam int LEN_W            = 6;
    localparam int BYTE_W           = 8;
    localparam int PEND_W           = 3;
    localparam int TOTAL_W          = 32;
    localparam int FUNC_W           = 2;
    localparam int DEF_MAX_CODE_LEN = 32;

    // Beat layout on the slave side: symbol, code_value, code_length.
    localparam int S_DATA_W = ((SYM_W + CODE_W + LEN_W + 7) / 8) * 8;
    // Beat layout on the master side: out_byte, total_bits.
    localparam int M_DATA_W = ((BYTE_W + TOTAL_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FLUSH  = 2'd2
    } func_t;

endpackage

### src/huffman_code_bit_packer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix-code bit packer
// Packs table-driven variable-length codes MSB first into a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one operation per beat: tuser selects a table
//   write, an encode or a flush; tdata carries symbol, code value and length.
//   A table write gives no beat. An encode reads the symbol's entry from
//   synchronous memory, then sends one master beat per completed byte, one
//   per cycle while the receiver is ready, the final one with tlast. Its
//   first byte goes through the table read register, the lookup state and
//   the emit state into the output register. A flush sends exactly one
//   beat with the padded partial byte, the stream's bit
//   count and tlast; tuser is low when no partial byte was pending.
//   No new operation is taken until the current one has finished.
//   Reset marks every table entry as empty (a symbol never written encodes
//   to nothing) and clears the accumulator and the bit count; no clearing
//   pass is needed. When the receiver stalls, the master beat holds in its
//   output register and the packer waits before loading the next byte.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // symbol [7:0], code_value [39:8], code_length [45:40], zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // func [1:0]
    input  logic [FUNC_W-1:0]   s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_byte [7:0], total_bits [39:8]
    output logic [M_DATA_W-1:0] m_tdata,
    // has_byte [0]
    output logic                m_tuser,
    output logic                m_tlast
);

    localparam int ACC_W = MAX_CODE_LEN + BYTE_W - 1;
    localparam int N_W   = $clog2(ACC_W + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_EMIT   = 4'b0100,
        S_FLUSH  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [BYTE_W-1:0]    bit_acc_reg, bit_acc_next;
    logic [PEND_W-1:0]    pending_reg, pending_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [N_W-1:0]       n_reg, n_next;

    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic [TOTAL_W-1:0]   out_total_reg, out_total_next;
    logic                 out_has_reg, out_has_next;
    logic                 out_last_reg, out_last_next;

    // Code table: values have no reset, lengths are qualified by valid bits.
    logic [CODE_W-1:0]    code_mem [TABLE_DEPTH];
    logic [LEN_W-1:0]     len_mem  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] len_valid_reg;
    logic [CODE_W-1:0]    code_rd_reg;
    logic [LEN_W-1:0]     len_rd_reg;
    logic                 len_valid_rd_reg;

    logic                 in_accept;
    func_t                in_func;
    logic [SYM_W-1:0]     in_symbol;
    logic [CODE_W-1:0]    in_code;
    logic [LEN_W-1:0]     in_len;
    logic [LEN_W-1:0]     in_len_clamped;
    logic                 out_free;

    logic [LEN_W-1:0]     len_eff;
    logic [ACC_W-1:0]     code_bits;
    logic [ACC_W-1:0]     acc_lookup;
    logic [N_W-1:0]       n_lookup;
    logic [TOTAL_W:0]     total_sum;
    logic [N_W-1:0]       n_emit;
    logic [BYTE_W-1:0]    emit_byte;
    logic [BYTE_W-1:0]    rem_mask;

    assign in_func   = func_t'(s_tuser);
    assign in_symbol = s_tdata[SYM_W-1:0];
    assign in_code   = s_tdata[SYM_W +: CODE_W];
    assign in_len    = s_tdata[SYM_W + CODE_W +: LEN_W];
    assign in_len_clamped = (in_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : in_len;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // Table write and read share the accept cycle; the read returns next cycle.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            code_rd_reg      <= code_mem[in_symbol];
            len_rd_reg       <= len_mem[in_symbol];
            len_valid_rd_reg <= len_valid_reg[in_symbol];
            if (in_func == FUNC_WRITE)
            begin
                code_mem[in_symbol] <= in_code;
                len_mem[in_symbol]  <= in_len_clamped;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_valid_reg <= '0;
        end
        else if (in_accept && (in_func == FUNC_WRITE))
        begin
            len_valid_reg[in_symbol] <= 1'b1;
        end
    end

    // Lookup datapath: append the masked code below the pending bits.
    assign len_eff    = len_valid_rd_reg ? len_rd_reg : '0;
    assign code_bits  = ACC_W'(code_rd_reg) & ~({ACC_W{1'b1}} << len_eff);
    assign acc_lookup = (ACC_W'(bit_acc_reg) << len_eff) | code_bits;
    assign n_lookup   = N_W'(pending_reg) + N_W'(len_eff);
    assign total_sum  = {1'b0, total_reg} + (TOTAL_W+1)'(len_eff);

    // Emit datapath: the next byte sits just above the bits still to send.
    assign n_emit    = n_reg - N_W'(BYTE_W);
    assign emit_byte = BYTE_W'(acc_reg >> n_emit);
    assign rem_mask  = ~({BYTE_W{1'b1}} << n_emit);

    always_comb
    begin
        state_next     = state_reg;
        bit_acc_next   = bit_acc_reg;
        pending_next   = pending_reg;
        total_next     = total_reg;
        acc_next       = acc_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_total_next = out_total_reg;
        out_has_next   = out_has_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_func)
                        FUNC_ENCODE: state_next = S_LOOKUP;
                        FUNC_FLUSH:  state_next = S_FLUSH;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_LOOKUP:
            begin
                if (len_eff == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    total_next = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
                    if (n_lookup >= N_W'(BYTE_W))
                    begin
                        acc_next   = acc_lookup;
                        n_next     = n_lookup;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        bit_acc_next = BYTE_W'(acc_lookup);
                        pending_next = PEND_W'(n_lookup);
                        state_next   = S_IDLE;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = emit_byte;
                    out_total_next = '0;
                    out_has_next   = 1'b1;
                    out_last_next  = (n_emit < N_W'(BYTE_W));
                    n_next         = n_emit;
                    if (n_emit < N_W'(BYTE_W))
                    begin
                        bit_acc_next = BYTE_W'(acc_reg) & rem_mask;
                        pending_next = PEND_W'(n_emit);
                        state_next   = S_IDLE;
                    end
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_has_next   = (pending_reg != '0);
                    out_byte_next  = BYTE_W'(bit_acc_reg << (4'd8 - {1'b0, pending_reg}));
                    out_total_next = total_reg;
                    out_last_next  = 1'b1;
                    bit_acc_next   = '0;
                    pending_next   = '0;
                    total_next     = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bit_acc_reg   <= '0;
            pending_reg   <= '0;
            total_reg     <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_acc_reg   <= bit_acc_next;
            pending_reg   <= pending_next;
            total_reg     <= total_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        out_byte_reg  <= out_byte_next;
        out_total_reg <= out_total_next;
        out_has_reg   <= out_has_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_total_reg, out_byte_reg});
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // The emit state is only entered with at least one full byte queued.
    a_emit_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (n_reg >= N_W'(BYTE_W)))
        else $error("emit state without a full byte");

    // A beat without a real byte only comes from a flush, which ends its run.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_has_reg) |-> out_last_reg)
        else $error("empty beat that is not last");

    // Bits above the pending count stay clear between items.
    a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((bit_acc_reg >> pending_reg) == '0))
        else $error("stale bits above pending count");

    // A completed flush leaves the stream state cleared.
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && out_free) |=> (pending_reg == '0 && total_reg == '0))
        else $error("flush did not clear stream state");
`endif

endmodule

### tb/huffman_code_bit_packer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix-code bit packer testbench
// Loads code table entries, encodes symbols and flushes streams through the
// slave channel, and checks each master beat against a predictor of the
// packer. Sender and receiver idle at random, and the receiver holds off
// once for a long stretch so that the packer fills up and stalls its input.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_test;
    import hcbp_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int CODE_LSB  = SYM_W;
    localparam int LEN_LSB   = SYM_W + CODE_W;
    localparam int ITEMS     = 450;
    localparam int SQUEEZE   = 400;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               has_byte;
        logic [TOTAL_W-1:0] total_bits;
        logic               last;
    } code_beat_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              typed;
        code_beat_t        want;
    } step_row_t;

    localparam code_beat_t NO_BEAT = '0;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0]   s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    // Travels with the slave beat: the beat's result is typed in by hand.
    logic                s_typed = 1'b0;
    code_beat_t          typed_beat = '0;

    // Predictor state.
    logic [CODE_W-1:0]   sym_code [TABLE_DEPTH];
    logic [LEN_W-1:0]    sym_len [TABLE_DEPTH];
    logic [BYTE_W-1:0]   acc_bits = '0;
    logic [PEND_W-1:0]   acc_count = '0;
    logic [TOTAL_W-1:0]  stream_bits = '0;

    code_beat_t          owed_beats [$];
    int                  mismatches = 0;
    int                  no_gap_left = 0;
    bit                  squeeze_req = 1'b0;

    huffman_code_bit_packer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Applies one operation to the predictor state. When keep is set, the
    // bytes it produces are queued as owed master beats.
    task automatic pack_codes(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] sym,
                              input logic [CODE_W-1:0] code,
                              input logic [LEN_W-1:0] len, input bit keep);
        logic [63:0]        window;
        logic [TOTAL_W:0]   sum;
        logic [BYTE_W-1:0]  padded;
        int                 width;
        int                 fill;
        code_beat_t         made [$];
        code_beat_t         one;
        if (f == FUNC_WRITE)
        begin
            sym_code[sym] = code;
            sym_len[sym]  = (len > DEF_MAX_CODE_LEN) ? LEN_W'(DEF_MAX_CODE_LEN) : len;
        end
        else if (f == FUNC_ENCODE && sym_len[sym] != 0)
        begin
            width  = sym_len[sym];
            window = (64'(acc_bits) << width) | (64'(sym_code[sym]) & ((64'd1 << width) - 1));
            fill   = acc_count + width;
            sum    = {1'b0, stream_bits} + width;
            stream_bits = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            while (fill >= BYTE_W)
            begin
                fill -= BYTE_W;
                one = '{BYTE_W'(window >> fill), 1'b1, '0, 1'b0};
                made.push_back(one);
            end
            acc_bits  = BYTE_W'(window & ((64'd1 << fill) - 1));
            acc_count = PEND_W'(fill);
            if (made.size() != 0)
                made[$].last = 1'b1;
        end
        else if (f == FUNC_FLUSH)
        begin
            padded = acc_bits << (BYTE_W - acc_count);
            if (acc_count != 0)
                one = '{padded, 1'b1, stream_bits, 1'b1};
            else
                one = '{'0, 1'b0, stream_bits, 1'b1};
            made.push_back(one);
            acc_bits    = '0;
            acc_count   = '0;
            stream_bits = '0;
        end
        if (keep)
            foreach (made[i])
                owed_beats.push_back(made[i]);
    endtask

    always @(posedge clk)
    begin : scoreboard
        code_beat_t got;
        code_beat_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                pack_codes(s_tuser, s_tdata[SYM_W-1:0], s_tdata[CODE_LSB +: CODE_W],
                           s_tdata[LEN_LSB +: LEN_W], !s_typed);
                if (s_typed)
                    owed_beats.push_back(typed_beat);
            end
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[BYTE_W-1:0], m_tuser, m_tdata[BYTE_W +: TOTAL_W], m_tlast};
                if (owed_beats.size() == 0)
                begin
                    $error("unexpected master beat: out_byte %0h total_bits %0d",
                           got.out_byte, got.total_bits);
                    mismatches++;
                end
                else
                begin
                    want = owed_beats.pop_front();
                    if (got.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                        mismatches++;
                    end
                    if (got.has_byte !== want.has_byte)
                    begin
                        $error("has_byte: expected %0b, got %0b", want.has_byte, got.has_byte);
                        mismatches++;
                    end
                    if (got.total_bits !== want.total_bits)
                    begin
                        $error("total_bits: expected %0d, got %0d",
                               want.total_bits, got.total_bits);
                        mismatches++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, got.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Mostly back to back or short gaps, a few long ones, and now and then
    // a run of beats with no gap at all.
    function automatic int sender_gap();
        int roll;
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
            no_gap_left = 30;
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic [LEN_W-1:0] pick_code_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return LEN_W'($urandom_range(1, 10));
        if (roll < 90)
            return LEN_W'($urandom_range(11, DEF_MAX_CODE_LEN));
        return LEN_W'($urandom_range(0, 63));
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                             input logic typed, input code_beat_t want);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser    <= f;
        s_tdata    <= {{(S_DATA_W - LEN_LSB - LEN_W){1'b0}}, len, code, sym};
        s_typed    <= typed;
        typed_beat <= want;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    initial
    begin : receiver
        bit squeezed;
        int run;
        squeezed = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (squeeze_req && !squeezed)
            begin
                squeezed = 1'b1;
                m_tready <= 1'b0;
                repeat (SQUEEZE) @(posedge clk);
            end
            else if ($urandom_range(0, 99) < 40)
            begin
                m_tready <= 1'b0;
                if ($urandom_range(0, 99) < 85)
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                else
                    repeat ($urandom_range(5, 30)) @(posedge clk);
            end
            m_tready <= 1'b1;
            run = ($urandom_range(0, 99) < 10) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        step_row_t       plan [24];
        logic [SYM_W-1:0] known_syms [$];
        logic [SYM_W-1:0] sym;
        int               counted;
        int               roll;

        // Typed rows are flushes whose result is plain from the stream so far.
        plan = '{
            '{FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, '{8'h00, 1'b0, 32'd0, 1'b1}},
            '{FUNC_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
            '{FUNC_WRITE,  8'h00, 32'hFFFF_FFFF, 6'd32, 1'b0, NO_BEAT},
            '{FUNC_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
            '{FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, '{8'h00, 1'b0, 32'd32, 1'b1}},
            '{FUNC_WRITE,  8'hFF, 32'h0000_0005, 6'd3,  1'b0, NO_BEAT},
            '{FUNC_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
            '{FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, '{8'hA0, 1'b1, 32'd3, 1'b1}},
            '{FUNC_WRITE,  8'h01, 32'hABCD_1234, 6'd63, 1'b0, NO_BEAT},
            '{FUNC_WRITE,  8'h02, 32'hFFFF_FFFE, 6'd1,  1'b0, NO_BEAT},
            '{FUNC_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
            '{FUNC_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
            '{FUNC_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
            '{FUNC_WRITE,  8'h03, 32'hFFFF_FFFF, 6'd0,  1'b0, NO_BEAT},
            '{FUNC_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
            '{FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b0, NO_BEAT},
            '{FUNC_WRITE,  8'h80, 32'h0000_007F, 6'd7,  1'b0, NO_BEAT},
            '{FUNC_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
            '{FUNC_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
            '{FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
            '{FUNC_WRITE,  8'h04, 32'h0000_0000, 6'd33, 1'b0, NO_BEAT},
            '{FUNC_ENCODE, 8'h04, 32'h0000_0000, 6'd0,  1'b0, NO_BEAT},
            '{FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, '{8'h00, 1'b0, 32'd32, 1'b1}},
            '{FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, '{8'h00, 1'b0, 32'd0, 1'b1}}
        };

        foreach (sym_len[i])
        begin
            sym_len[i]  = '0;
            sym_code[i] = '0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_beat(plan[i].func, plan[i].sym, plan[i].code, plan[i].len,
                      plan[i].typed, plan[i].want);

        // Load a table first so that most encodes below produce bits.
        squeeze_req = 1'b1;
        for (counted = 0; counted < 24; counted++)
        begin
            sym = SYM_W'($urandom_range(0, 255));
            known_syms.push_back(sym);
            send_beat(FUNC_WRITE, sym, $urandom(), pick_code_len(), 1'b0, NO_BEAT);
        end

        while (counted < ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
            begin
                sym = SYM_W'($urandom_range(0, 255));
                known_syms.push_back(sym);
                send_beat(FUNC_WRITE, sym, $urandom(), pick_code_len(), 1'b0, NO_BEAT);
                counted++;
            end
            else if (roll < 82)
            begin
                if ($urandom_range(0, 9) != 0)
                    sym = known_syms[$urandom_range(0, known_syms.size() - 1)];
                else
                    sym = SYM_W'($urandom_range(0, 255));
                send_beat(FUNC_ENCODE, sym, $urandom(), LEN_W'($urandom_range(0, 63)),
                          1'b0, NO_BEAT);
                counted++;
            end
            else if (roll < 95)
            begin
                send_beat(FUNC_FLUSH, SYM_W'($urandom_range(0, 255)), $urandom(),
                          LEN_W'($urandom_range(0, 63)), 1'b0, NO_BEAT);
                counted++;
            end
            else
                send_beat(FUNC_UNUSED, SYM_W'($urandom_range(0, 255)), $urandom(),
                          LEN_W'($urandom_range(0, 63)), 1'b0, NO_BEAT);
        end
        s_tvalid <= 1'b0;

        while (owed_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && owed_beats.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
